// ===== rtl/core/grne_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the grid radius neighbour edge scanner
package grne_pkg;

    localparam int FIELD_W    = 9;
    localparam int OPCODE_W   = 2;
    localparam int RADIUS_W   = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd60;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

    typedef struct packed {
        logic on_grid;
        logic in_range;
    } geom_status_t;

endpackage

// ===== rtl/core/grid_radius_neighbor_edges.sv =====
`timescale 1ns / 1ps
// Grid radius neighbour edge scanner. After reset the occupancy bitmap is
// swept to empty, one cell per cycle across all 2**(clog2(GRID_ROWS)+clog2(GRID_COLS))
// cells (262144 at the defaults); no request is taken during that sweep, while
// radius writes are. Write and start requests are taken in idle. A step request
// passes through source cell read, candidate cell read and evaluate while a scan
// runs and straight to evaluate when none runs, the reads sharing the single read
// port of the bitmap memory; evaluate waits for a free output register. One result
// per step is held there, so the next request is taken while it waits to be collected.
module grid_radius_neighbor_edges import grne_pkg::*; #(
    parameter int GRID_ROWS  = 512,
    parameter int GRID_COLS  = 512,
    parameter int MAX_RADIUS = 127
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // radius write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIUS_W-1:0]   cfg_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row, col, occupied, zero pad
    input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // from_row, from_col, to_row, to_col, zero pad
    output logic                  m_axis_tuser,  // edge_found
    output logic                  m_axis_tlast   // scan_done
);

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int OFF_W  = RAD_W + 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SRC   = 3'd2;
    localparam logic [2:0] ST_CAND  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic [RAD_W-1:0]    scan_radius_reg, scan_radius_next;
    logic [ROW_W-1:0]    source_row_reg, source_row_next;
    logic [COL_W-1:0]    source_col_reg, source_col_next;
    logic [OFF_W-1:0]    row_off_reg, row_off_next;
    logic [OFF_W-1:0]    col_off_reg, col_off_next;
    logic                scan_running_reg, scan_running_next;
    logic                scan_finished_reg, scan_finished_next;
    logic                src_occ_reg;

    logic                out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]  from_row_reg, from_row_next;
    logic [FIELD_W-1:0]  from_col_reg, from_col_next;
    logic [FIELD_W-1:0]  to_row_reg, to_row_next;
    logic [FIELD_W-1:0]  to_col_reg, to_col_next;
    logic                edge_reg, edge_next;
    logic                done_reg, done_next;

    logic                in_fire;
    logic                out_free;
    logic [FIELD_W-1:0]  in_row;
    logic [FIELD_W-1:0]  in_col;
    logic                in_occ;
    logic                in_grid;
    logic [OFF_W-1:0]    off_last;
    logic [RAD_W-1:0]    radius_sat;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                ram_rdata;

    logic [ROW_W-1:0]    cand_row;
    logic [COL_W-1:0]    cand_col;
    geom_status_t        geom_status;

    assign in_row = s_axis_tdata[FIELD_W-1:0];
    assign in_col = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign in_occ = s_axis_tdata[2*FIELD_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_grid       = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
    assign off_last      = {scan_radius_reg, 1'b0} - OFF_W'(1);
    assign radius_sat    = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                          : RAD_W'(radius_reg);

    grne_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grne_geom #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_geom (
        .clk      (clk),
        .calc_en  (state_reg == ST_SRC),
        .cmp_en   (state_reg == ST_CAND),
        .src_row  (source_row_reg),
        .src_col  (source_col_reg),
        .row_off  (row_off_reg),
        .col_off  (col_off_reg),
        .radius   (scan_radius_reg),
        .cand_row (cand_row),
        .cand_col (cand_col),
        .status   (geom_status)
    );

    // bitmap port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {ROW_W'(in_row), COL_W'(in_col)};
        ram_wdata = in_occ;
        ram_re    = 1'b0;
        ram_raddr = {source_row_reg, source_col_reg};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else if (in_fire && s_axis_tuser == OP_WRITE && in_grid)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == ST_SRC)
        begin
            ram_re = 1'b1;
        end
        else if (state_reg == ST_CAND)
        begin
            ram_re    = 1'b1;
            ram_raddr = {cand_row, cand_col};
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        radius_next        = radius_reg;
        scan_radius_next   = scan_radius_reg;
        source_row_next    = source_row_reg;
        source_col_next    = source_col_reg;
        row_off_next       = row_off_reg;
        col_off_next       = col_off_reg;
        scan_running_next  = scan_running_reg;
        scan_finished_next = scan_finished_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        from_row_next      = from_row_reg;
        from_col_next      = from_col_reg;
        to_row_next        = to_row_reg;
        to_col_next        = to_col_reg;
        edge_next          = edge_reg;
        done_next          = done_reg;

        if (cfg_valid)
        begin
            radius_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        OP_START:
                        begin
                            source_row_next    = '0;
                            source_col_next    = '0;
                            row_off_next       = '0;
                            col_off_next       = '0;
                            scan_running_next  = 1'b1;
                            scan_finished_next = 1'b0;
                            scan_radius_next   = radius_sat;
                        end
                        OP_STEP:
                        begin
                            state_next = scan_running_reg ? ST_SRC : ST_EVAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SRC:
            begin
                state_next = ST_CAND;
            end
            ST_CAND:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    from_row_next  = '0;
                    from_col_next  = '0;
                    to_row_next    = '0;
                    to_col_next    = '0;
                    edge_next      = 1'b0;
                    done_next      = scan_finished_reg;
                    if (scan_running_reg)
                    begin
                        from_row_next = FIELD_W'(source_row_reg);
                        from_col_next = FIELD_W'(source_col_reg);
                        done_next     = 1'b0;
                        if (scan_radius_reg != '0 && src_occ_reg)
                        begin
                            if (geom_status.on_grid && geom_status.in_range && ram_rdata)
                            begin
                                edge_next   = 1'b1;
                                to_row_next = FIELD_W'(cand_row);
                                to_col_next = FIELD_W'(cand_col);
                            end
                            col_off_next = col_off_reg + OFF_W'(1);
                        end
                        // zero radius, empty source, or the window has been walked to its end
                        if (scan_radius_reg == '0 || !src_occ_reg
                            || (col_off_reg == off_last && row_off_reg == off_last))
                        begin
                            row_off_next    = '0;
                            col_off_next    = '0;
                            source_col_next = source_col_reg + COL_W'(1);
                            if (32'(source_col_reg) == GRID_COLS - 1)
                            begin
                                source_col_next = '0;
                                source_row_next = source_row_reg + ROW_W'(1);
                                if (32'(source_row_reg) == GRID_ROWS - 1)
                                begin
                                    source_row_next    = '0;
                                    scan_running_next  = 1'b0;
                                    scan_finished_next = 1'b1;
                                    done_next          = 1'b1;
                                end
                            end
                        end
                        else if (col_off_reg == off_last)
                        begin
                            col_off_next = '0;
                            row_off_next = row_off_reg + OFF_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            radius_reg        <= RADIUS_RESET;
            scan_radius_reg   <= '0;
            source_row_reg    <= '0;
            source_col_reg    <= '0;
            row_off_reg       <= '0;
            col_off_reg       <= '0;
            scan_running_reg  <= 1'b0;
            scan_finished_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            radius_reg        <= radius_next;
            scan_radius_reg   <= scan_radius_next;
            source_row_reg    <= source_row_next;
            source_col_reg    <= source_col_next;
            row_off_reg       <= row_off_next;
            col_off_reg       <= col_off_next;
            scan_running_reg  <= scan_running_next;
            scan_finished_reg <= scan_finished_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CAND)
        begin
            src_occ_reg <= ram_rdata;
        end
        from_row_reg <= from_row_next;
        from_col_reg <= from_col_next;
        to_row_reg   <= to_row_next;
        to_col_reg   <= to_col_next;
        edge_reg     <= edge_next;
        done_reg     <= done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 4*FIELD_W)'(0), to_col_reg, to_row_reg,
                            from_col_reg, from_row_reg};
    assign m_axis_tuser  = edge_reg;
    assign m_axis_tlast  = done_reg;

    a_eval_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && out_free) |=> m_axis_tvalid)
        else $error("evaluated step did not produce a result");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result present during bitmap clear");

    a_offsets_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_running_reg && scan_radius_reg != '0)
            |-> (row_off_reg <= off_last && col_off_reg <= off_last))
        else $error("window offset beyond window");

    a_idle_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && (&clr_cnt_reg)) |=> s_axis_tready)
        else $error("not ready after bitmap clear");

endmodule

// ===== rtl/core/grne_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
module grne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 262144,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/grne_geom.sv =====
`timescale 1ns / 1ps
// window geometry: candidate coordinates, grid bounds and squared distance test
module grne_geom import grne_pkg::*; #(
    parameter int GRID_ROWS  = 512,
    parameter int GRID_COLS  = 512,
    parameter int MAX_RADIUS = 127,
    localparam int ROW_W = $clog2(GRID_ROWS),
    localparam int COL_W = $clog2(GRID_COLS),
    localparam int RAD_W = $clog2(MAX_RADIUS + 1),
    localparam int OFF_W = RAD_W + 1
) (
    input  logic             clk,
    input  logic             calc_en,
    input  logic             cmp_en,
    input  logic [ROW_W-1:0] src_row,
    input  logic [COL_W-1:0] src_col,
    input  logic [OFF_W-1:0] row_off,
    input  logic [OFF_W-1:0] col_off,
    input  logic [RAD_W-1:0] radius,
    output logic [ROW_W-1:0] cand_row,
    output logic [COL_W-1:0] cand_col,
    output geom_status_t     status
);

    localparam int D_W  = OFF_W + 1;
    localparam int SQ_W = 2 * D_W;
    localparam int SR_W = ((ROW_W > D_W) ? ROW_W : D_W) + 2;
    localparam int SC_W = ((COL_W > D_W) ? COL_W : D_W) + 2;

    logic signed [D_W-1:0]  di;
    logic signed [D_W-1:0]  dj;
    logic signed [SQ_W-1:0] di_sq_next;
    logic signed [SQ_W-1:0] dj_sq_next;
    logic [SQ_W-1:0]        r_sq_next;
    logic signed [SR_W-1:0] a;
    logic signed [SC_W-1:0] b;
    logic                   inside_next;
    logic [SQ_W:0]          dist_sq;
    logic                   in_range_next;

    logic [SQ_W-1:0]  di_sq_reg;
    logic [SQ_W-1:0]  dj_sq_reg;
    logic [SQ_W-1:0]  r_sq_reg;
    logic [ROW_W-1:0] cand_row_reg;
    logic [COL_W-1:0] cand_col_reg;
    logic             inside_reg;
    logic             in_range_reg;

    // offsets run from 0 to 2r-1, so di and dj span -r..r-1
    always_comb
    begin
        di = signed'({1'b0, row_off}) - D_W'(signed'({1'b0, radius}));
        dj = signed'({1'b0, col_off}) - D_W'(signed'({1'b0, radius}));
        di_sq_next = SQ_W'(di) * SQ_W'(di);
        dj_sq_next = SQ_W'(dj) * SQ_W'(dj);
        r_sq_next  = SQ_W'(radius) * SQ_W'(radius);
        a = SR_W'(signed'({1'b0, src_row})) + SR_W'(di);
        b = SC_W'(signed'({1'b0, src_col})) + SC_W'(dj);
        inside_next = !a[SR_W-1] && (a < signed'(SR_W'(GRID_ROWS)))
                   && !b[SC_W-1] && (b < signed'(SC_W'(GRID_COLS)));
        dist_sq = {1'b0, di_sq_reg} + {1'b0, dj_sq_reg};
        in_range_next = dist_sq <= {1'b0, r_sq_reg};
    end

    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            di_sq_reg    <= di_sq_next;
            dj_sq_reg    <= dj_sq_next;
            r_sq_reg     <= r_sq_next;
            cand_row_reg <= a[ROW_W-1:0];
            cand_col_reg <= b[COL_W-1:0];
            inside_reg   <= inside_next;
        end
        if (cmp_en)
        begin
            in_range_reg <= in_range_next;
        end
    end

    assign cand_row        = cand_row_reg;
    assign cand_col        = cand_col_reg;
    assign status.on_grid  = inside_reg;
    assign status.in_range = in_range_reg;

endmodule
